[sv/assert_macros.svh]
// Assertion helpers. Clock and reset are taken from the using scope (clk, arst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, cond) \
	`ASSERT_CLK(lbl, !(cond))

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

[sv/wbps_pkg.sv]
`default_nettype none
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// fixed by the register map
	localparam int PAT_BYTES = 16;
	localparam int LEN_REG_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam int OUT_OFFSET_W = 32;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_CARE     = 2'd2,
		REG_LENGTH   = 2'd3
	} cfg_reg_t;

	// found in bit 0, offset above it
	typedef struct packed {
		logic [OUT_OFFSET_W-1:0] match_offset;
		logic                    found;
	} result_t;

	typedef struct packed {
		logic push;
		logic done;
	} fe_stat_t;

endpackage
`default_nettype wire

[sv/wildcard_byte_pattern_search.sv]
`default_nettype none
// Wildcard byte pattern search. Bytes of a region arrive one per word on s_*,
// tlast marking the region's last byte. The newest pattern_length bytes are
// compared each cycle against the configured pattern (care_mask clear = any
// byte). The first matching window gives one word on m_*: found = 1 and the
// offset of the window's first byte; a region ending with no match gives
// found = 0, offset 0. One word at most per region; state clears after tlast,
// and bytes after a match are only counted. Throughput is one byte per clock
// while the queue is not full: the masked compare is a combinational
// parallel equality in the front end. Each result word passes through a
// two-entry result queue and then the output register, which let the input
// keep flowing while a result waits; s_tready drops only when the queue is
// full. Registers (cfg_index): 0 pattern bytes 0-7, 1 pattern bytes 8-15,
// 2 care mask, 3 pattern length (0 reads as 1, above MaxPattern as
// MaxPattern). Write configuration only between regions; cfg_ready is always
// high. The byte offset counter saturates at 2^OffsetBits - 1.
module wildcard_byte_pattern_search #(
	parameter int MaxPattern = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OffsetBits = wbps_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
	// byte stream in
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [wbps_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
	input  wire logic                            s_tlast,  // region_end
	// result stream out
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [wbps_pkg::M_TDATA_W-1:0]       m_tdata   // [0] found, [32:1] match_offset
);
`include "assert_macros.svh"

	logic               accept;
	logic               q_full, q_not_empty, q_pop;
	wbps_pkg::result_t  fe_result, q_data;
	wbps_pkg::fe_stat_t fe_stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;

	// front end: window, compare, region bookkeeping
	wbps_front #(
		.MaxPattern (MaxPattern),
		.OffsetBits (OffsetBits)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (s_tdata[7:0]),
		.region_end (s_tlast),
		.result     (fe_result),
		.stat       (fe_stat)
	);

	// result queue between front and back
	wbps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_stat.push),
		.wr_data   (fe_result),
		.pop       (q_pop),
		.rd_data   (q_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// back end: output register
	wbps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// a result only comes from an accepted byte
	`ASSERT_CLK(a_push_needs_accept, fe_stat.push |-> accept)
	// the queue is never written when full
	`ASSERT_NEVER(a_no_overflow, fe_stat.push && q_full)
	// a region that has not reported yet always reports at its last byte
	`ASSERT_CLK(a_end_reports, (accept && s_tlast && !fe_stat.done) |-> fe_stat.push)

endmodule
`default_nettype wire

[sv/wbps_front.sv]
`default_nettype none
module wbps_front #(
	parameter int MaxPattern = wbps_pkg::MAX_PATTERN_DEF,
	parameter int OffsetBits = wbps_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            accept,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            region_end,
	output wbps_pkg::result_t                    result,
	output wbps_pkg::fe_stat_t                   stat
);
	localparam int LenW = $clog2(MaxPattern + 1);
	localparam int CmpW = (LenW > wbps_pkg::LEN_REG_W) ? LenW : wbps_pkg::LEN_REG_W;
	localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

	logic [63:0]                     pat_low_q, pat_high_q;
	logic [wbps_pkg::PAT_BYTES-1:0]  care_q;
	logic [wbps_pkg::LEN_REG_W-1:0]  plen_q;

	logic [7:0]            win_q [MaxPattern];
	logic [7:0]            win_n [MaxPattern];
	logic [OffsetBits-1:0] seen_q, seen_n, off_full;
	logic                  done_q;

	logic [CmpW-1:0] plen_x, eff_len;
	logic [127:0]    pat_flat;
	logic            match, hit, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			plen_q     <= wbps_pkg::LEN_REG_W'(1);
		end else if (cfg_we) begin
			case (wbps_pkg::cfg_reg_t'(cfg_index))
				wbps_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				wbps_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				wbps_pkg::REG_CARE:     care_q     <= cfg_data[wbps_pkg::PAT_BYTES-1:0];
				wbps_pkg::REG_LENGTH:   plen_q     <= cfg_data[wbps_pkg::LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp length to 1..MaxPattern
	always_comb begin
		plen_x = CmpW'(plen_q);
		if (plen_x == '0)
			eff_len = CmpW'(1);
		else if (plen_x > CmpW'(MaxPattern))
			eff_len = CmpW'(MaxPattern);
		else
			eff_len = plen_x;
	end

	always_comb begin
		win_n[0] = data_byte;
		for (int i = 1; i < MaxPattern; i++)
			win_n[i] = win_q[i-1];
	end

	assign pat_flat = {pat_high_q, pat_low_q};

	// pattern byte k lines up with the byte (len-1-k) steps back
	always_comb begin
		logic [CmpW-1:0] idx;
		logic [3:0]      kk;
		logic            ok;
		match = 1'b1;
		for (int k = 0; k < MaxPattern; k++) begin
			idx = eff_len - CmpW'(1) - CmpW'(k);
			kk  = 4'(k);
			ok  = 1'b1;
			if (k < wbps_pkg::PAT_BYTES && CmpW'(k) < eff_len && care_q[kk])
				ok = (pat_flat[{kk, 3'b000} +: 8] == win_n[idx[IdxW-1:0]]);
			match = match & ok;
		end
	end

	assign seen_n   = (seen_q == '1) ? seen_q : seen_q + OffsetBits'(1);
	assign off_full = seen_n - OffsetBits'(eff_len);
	assign hit      = !done_q && (seen_n >= OffsetBits'(eff_len)) && match;
	assign push     = accept && (hit || (region_end && !done_q));

	assign result.found        = hit;
	assign result.match_offset = hit ? wbps_pkg::OUT_OFFSET_W'(off_full) : '0;
	assign stat.push           = push;
	assign stat.done           = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (region_end) begin
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				seen_q <= seen_n;
				done_q <= done_q | hit;
			end
		end
	end

	// window bytes are only read once a full pattern length has arrived
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MaxPattern; i++)
				win_q[i] <= win_n[i];
		end
	end

endmodule
`default_nettype wire

[sv/wbps_queue.sv]
`default_nettype none
module wbps_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wbps_pkg::result_t wr_data,
	input  wire logic              pop,
	output wbps_pkg::result_t      rd_data,
	output logic                   full,
	output logic                   not_empty
);
	localparam int PtrW = (wbps_pkg::QUEUE_DEPTH > 1) ? $clog2(wbps_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(wbps_pkg::QUEUE_DEPTH + 1);

	wbps_pkg::result_t mem_q [wbps_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(wbps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign full      = (count_q == CntW'(wbps_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)
				rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

[sv/wbps_back.sv]
`default_nettype none
module wbps_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_not_empty,
	input  wire wbps_pkg::result_t               q_data,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [wbps_pkg::M_TDATA_W-1:0]       m_tdata
);
	logic              valid_q;
	wbps_pkg::result_t data_q;

	assign q_pop    = q_not_empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = wbps_pkg::M_TDATA_W'(data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || m_tready)
			valid_q <= q_not_empty;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			data_q <= q_data;
	end

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RES_W = $bits(wbps_pkg::result_t);
	// settle time after the owed results are out, with margin over the queue and output register
	localparam int SETTLE_CYCLES = 4;
	// long receiver hold-off: enough for the result queue to fill and s_tready to drop
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_BYTES = 1250;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	// receiver ready styles, picked per register setting
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_PERIODIC
	} ready_style_t;

	// Mirror of the search: register copies, sliding window, offset counter,
	// and the queue of result words still owed by the block.
	class search_tracker;
		logic [wbps_pkg::CFG_DATA_W-1:0]      pat_low;
		logic [wbps_pkg::CFG_DATA_W-1:0]      pat_high;
		logic [wbps_pkg::PAT_BYTES-1:0]       care;
		logic [wbps_pkg::LEN_REG_W-1:0]       len_reg;
		logic [7:0]                           window [wbps_pkg::MAX_PATTERN_DEF];
		logic [wbps_pkg::OFFSET_BITS_DEF-1:0] seen;
		bit                                   reported;
		wbps_pkg::result_t                    expected_reports [$];
		int                                   errors;
		int                                   hits;
		int                                   misses;

		function new();
			pat_low = '0;
			pat_high = '0;
			care = '1;
			len_reg = 1;
			errors = 0;
			hits = 0;
			misses = 0;
			clear_region();
		endfunction

		function void clear_region();
			foreach (window[i]) window[i] = '0;
			seen = '0;
			reported = 1'b0;
		endfunction

		// length register as the compare uses it: 0 reads as 1, clamp at the window size
		function int span();
			if (len_reg == 0) return 1;
			if (len_reg > wbps_pkg::MAX_PATTERN_DEF) return wbps_pkg::MAX_PATTERN_DEF;
			return int'(len_reg);
		endfunction

		function void write_reg(wbps_pkg::cfg_reg_t idx,
				logic [wbps_pkg::CFG_DATA_W-1:0] value);
			case (idx)
			wbps_pkg::REG_PAT_LOW:  pat_low = value;
			wbps_pkg::REG_PAT_HIGH: pat_high = value;
			wbps_pkg::REG_CARE:     care = value[wbps_pkg::PAT_BYTES-1:0];
			wbps_pkg::REG_LENGTH:   len_reg = value[wbps_pkg::LEN_REG_W-1:0];
			default: ;
			endcase
		endfunction

		function bit position_ok(int k, logic [7:0] b);
			logic [8*wbps_pkg::PAT_BYTES-1:0] pat;
			pat = {pat_high, pat_low};
			if (k >= wbps_pkg::PAT_BYTES) return 1'b1;
			if (!care[k]) return 1'b1;
			return pat[8*k +: 8] == b;
		endfunction

		// one accepted byte: shift, count, compare, and queue any result it causes
		function void take_byte(logic [7:0] b, bit region_end);
			int n;
			bit hit;
			wbps_pkg::result_t r;
			n = span();
			for (int i = wbps_pkg::MAX_PATTERN_DEF - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = b;
			if (seen != '1) seen++;
			if (!reported && seen >= n) begin
				hit = 1'b1;
				// pattern byte k arrived n-1-k bytes ago
				for (int k = 0; k < n; k++) begin
					if (!position_ok(k, window[n-1-k])) hit = 1'b0;
				end
				if (hit) begin
					r.found = 1'b1;
					r.match_offset = seen - n;
					expected_reports.push_back(r);
					reported = 1'b1;
				end
			end
			if (region_end) begin
				if (!reported) begin
					r = '0;
					expected_reports.push_back(r);
				end
				clear_region();
			end
		endfunction

		function void check_report(logic [wbps_pkg::M_TDATA_W-1:0] word);
			wbps_pkg::result_t got;
			wbps_pkg::result_t want;
			got = word[RES_W-1:0];
			if (expected_reports.size() == 0) begin
				errors++;
				$error("result word with nothing expected: found=%0d offset=%0d",
					got.found, got.match_offset);
				return;
			end
			want = expected_reports.pop_front();
			if (want.found) hits++;
			else misses++;
			if (got.found !== want.found) begin
				errors++;
				$error("found: expected %0d, got %0d", want.found, got.found);
			end
			if (got.match_offset !== want.match_offset) begin
				errors++;
				$error("match_offset: expected %0d, got %0d", want.match_offset,
					got.match_offset);
			end
			if (word[wbps_pkg::M_TDATA_W-1:RES_W] !== '0) begin
				errors++;
				$error("tdata padding: expected 0, got %h",
					word[wbps_pkg::M_TDATA_W-1:RES_W]);
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	wbps_pkg::cfg_reg_t              cfg_index = wbps_pkg::REG_PAT_LOW;
	logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [wbps_pkg::S_TDATA_W-1:0]  s_tdata = '0;  // [7:0] data_byte
	logic                            s_tlast = 1'b0; // region_end
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [wbps_pkg::M_TDATA_W-1:0]  m_tdata;        // [0] found, [32:1] match_offset

	search_tracker tracker = new();

	// sender and receiver pacing
	int           burst_left = 0;
	bit           gaps_on = 1'b0;
	ready_style_t ready_style = READY_ALWAYS;
	int           hold_asked = 0;
	int           hold_taken = 0;
	int           hold_left = 0;
	int unsigned  ready_tick = 0;

	// register values as last written, used to build matching regions
	logic [8*wbps_pkg::PAT_BYTES-1:0] pat_now = '0;
	logic [wbps_pkg::PAT_BYTES-1:0]   care_now = '1;
	logic [7:0]                       region_bytes [$];

	int          bytes_sent = 0;
	int          regions_sent = 0;
	int          settings_used = 0;
	int unsigned stalled_cycles = 0;
	int unsigned cycle_count = 0;

	wildcard_byte_pattern_search u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4ns clk = 1'b1;
		#4ns clk = 1'b0;
	end

	// Watch all three channels at the edge; everything the testbench drives
	// changes by NBA, so these reads see the values the block sampled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) tracker.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) tracker.check_report(m_tdata);
		end
	end

	// Receiver. A requested hold-off wins; otherwise follow the current style.
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_taken + 1;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			case (ready_style)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
			READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
			default:      m_tready <= ((ready_tick % 5) < 2);
			endcase
		end
	end

	// Watchdog, plus a count of cycles where the block pushed back on input.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && s_tvalid && !s_tready) stalled_cycles++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
				tracker.expected_reports.size());
			$display("Verification failed");
			$finish;
		end
	end

	// One byte word. Bursts of random length; a random gap may open each burst.
	task automatic send_byte(input logic [7:0] b, input bit region_end);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= region_end;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_region();
		foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
		region_bytes.delete();
		regions_sent++;
	endtask

	function automatic void add_noise(int count);
		repeat (count) region_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// One window that fits the pattern, wildcards filled at random. With
	// spoil set, a randomly picked byte is flipped when cared so the copy misses.
	function automatic void add_copy(bit spoil);
		int n;
		int spot;
		n = tracker.span();
		spot = $urandom_range(0, n - 1);
		for (int k = 0; k < n; k++) begin
			if (care_now[k]) region_bytes.push_back(pat_now[8*k +: 8]);
			else region_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (spoil && care_now[spot])
			region_bytes[region_bytes.size() - n + spot] ^= 8'($urandom_range(1, 255));
	endfunction

	// Stop sending and let every owed result word out, then give the block
	// its latency so a byte without a result has fully passed through.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tracker.expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input wbps_pkg::cfg_reg_t idx,
			input logic [wbps_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// All four registers, only with the block idle. junk fills the unused
	// upper bits of the care and length words.
	task automatic set_config(input logic [wbps_pkg::CFG_DATA_W-1:0] low,
			input logic [wbps_pkg::CFG_DATA_W-1:0] high,
			input logic [wbps_pkg::PAT_BYTES-1:0] care_bits,
			input logic [wbps_pkg::LEN_REG_W-1:0] len,
			input logic [wbps_pkg::CFG_DATA_W-1:0] junk);
		drain();
		pat_now = {high, low};
		care_now = care_bits;
		cfg_put(wbps_pkg::REG_PAT_LOW, low);
		cfg_put(wbps_pkg::REG_PAT_HIGH, high);
		cfg_put(wbps_pkg::REG_CARE, {junk[wbps_pkg::CFG_DATA_W-1:wbps_pkg::PAT_BYTES], care_bits});
		cfg_put(wbps_pkg::REG_LENGTH, {junk[wbps_pkg::CFG_DATA_W-1:wbps_pkg::LEN_REG_W], len});
		cfg_valid <= 1'b0;
		// let the tracker take the length write before regions are built
		@(posedge clk);
		settings_used++;
	endtask

	initial begin
		int phase;
		int start;
		int budget;
		int kind;
		int n;
		logic [wbps_pkg::LEN_REG_W-1:0] len_pick;
		logic [wbps_pkg::PAT_BYTES-1:0] care_pick;
		logic [wbps_pkg::CFG_DATA_W-1:0] low_pick;
		logic [wbps_pkg::CFG_DATA_W-1:0] high_pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// reset registers: one byte, must be 0x00
		region_bytes = '{8'h00};                    // match on the last byte
		send_region();
		region_bytes = '{8'hFF, 8'h12, 8'h00, 8'hAA}; // bytes after a match
		send_region();
		region_bytes = '{8'hFF};                    // no match at all
		send_region();

		// length 0 acts as 1
		set_config(64'hFF, 64'h0, 16'hFFFF, 5'd0, 64'h0);
		region_bytes = '{8'h00, 8'hFF};
		send_region();

		// length 31 clamps to 16; a 3-byte region is too short to compare
		set_config(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'hFFFF, 5'd31, 64'h0);
		region_bytes = '{8'h11, 8'h22, 8'h33};
		send_region();

		// two bytes, second a wildcard: first window misses, second hits
		set_config(64'hA5, 64'h0, 16'h0001, 5'd2, 64'h0);
		region_bytes = '{8'h5A, 8'hA5, 8'h00};
		send_region();

		// --- random ---
		phase = 0;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			// early settings walk the register extremes
			case (phase)
			0: len_pick = 5'd0;
			1: len_pick = 5'd31;
			2: len_pick = 5'd16;
			3: len_pick = 5'd1;
			4: len_pick = 5'd17;
			default: len_pick = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 8))
				: 5'($urandom_range(0, 31));
			endcase
			case (phase)
			0: care_pick = 16'hFFFF;
			1: care_pick = 16'h0000;
			default: begin
				case ($urandom_range(0, 4))
				0: care_pick = 16'h0000;
				1: care_pick = 16'hFFFF;
				2: care_pick = 16'($urandom);
				default: care_pick = 16'($urandom | $urandom);
				endcase
			end
			endcase
			low_pick = {$urandom, $urandom};
			high_pick = {$urandom, $urandom};
			if (phase == 2) begin
				low_pick = '1;
				high_pick = '1;
			end else if (phase == 5) begin
				low_pick = '0;
				high_pick = '0;
			end
			set_config(low_pick, high_pick, care_pick, len_pick,
				(phase % 2) ? {$urandom, $urandom} : 64'h0);

			gaps_on = ($urandom_range(0, 3) != 0);
			ready_style <= ready_style_t'($urandom_range(0, 3));

			if (phase == 3) begin
				// receiver holds off while short regions stream in back to back;
				// each region owes one word, so the queue fills and input stalls
				hold_asked <= hold_asked + 1;
				gaps_on = 1'b0;
				repeat (40) begin
					add_noise($urandom_range(1, 3));
					send_region();
				end
			end else begin
				budget = bytes_sent + $urandom_range(60, 140);
				n = tracker.span();
				while (bytes_sent < budget) begin
					kind = $urandom_range(0, 19);
					if (kind <= 10) begin
						// well-formed: prefix, pattern copy, often-empty suffix
						add_noise($urandom_range(0, 10));
						add_copy(1'b0);
						add_noise(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
					end else if (kind <= 13) begin
						add_noise($urandom_range(0, 6));
						add_copy(1'b1);
						add_noise($urandom_range(0, 4));
					end else if (kind <= 16) begin
						add_noise($urandom_range(1, 24));
					end else if (kind <= 18) begin
						// shorter than the pattern where that is possible
						add_noise($urandom_range(1, (n > 1) ? n - 1 : 1));
					end else begin
						// two copies: only the first may report
						add_copy(1'b0);
						add_noise($urandom_range(0, 3));
						add_copy(1'b0);
					end
					send_region();
				end
			end
			phase++;
		end

		drain();

		$display("Ran %0d bytes in %0d regions across %0d register settings.",
			bytes_sent, regions_sent, settings_used);
		$display("Got %0d match and %0d no-match reports; input back-pressured %0d cycles.",
			tracker.hits, tracker.misses, stalled_cycles);
		if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_front.sv
sv/wbps_queue.sv
sv/wbps_back.sv
sv/wildcard_byte_pattern_search.sv
tb/testbench.sv
